[src/mnbi_pkg.sv]
// Package for the multichannel notch and bandpass IIR filter.
// Holds the coefficient tables, the fixed-point types and the shared codes.
// No dependencies.
`default_nettype none
package mnbi_pkg;

  localparam int NumChannels = 16;
  localparam int ChanW       = 4;
  localparam int Dly         = 4;
  localparam int HistDepth   = NumChannels * Dly;
  localparam int HistAw      = $clog2(HistDepth);
  localparam int SampleW     = 24;
  localparam int ValW        = 40;
  localparam int CoefW       = 32;

  typedef logic signed [ValW-1:0]  val_t;
  typedef logic signed [CoefW-1:0] coef_t;

  localparam logic [0:0] CfgNotch = 1'b0;
  localparam logic [0:0] CfgBand  = 1'b1;

  // Design value in units of 1e-9, rounded to nearest in Q4.28.
  function automatic coef_t q28(input longint n);
    longint m;
    m = (n >= 0) ? n : -n;
    m = (m * 64'sd268435456 + 64'sd500000000) / 64'sd1000000000;
    return (n >= 0) ? coef_t'(m) : coef_t'(-m);
  endfunction

  // Notch coefficients, b0..b4 then a1..a4, Q4.28; row 0 is the pass-through.
  localparam coef_t NotchRom [3][9] = '{
    '{q28(64'sd1000000000), 32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{q28(64'sd965080990), q28(-64'sd1193282550), q28(64'sd2299023050),
      q28(-64'sd1193282550), q28(64'sd965080990), q28(-64'sd1214493480),
      q28(64'sd2297803340), q28(-64'sd1172071630), q28(64'sd931381680)},
    '{q28(64'sd965080986), q28(-64'sd242468320), q28(64'sd1945391494),
      q28(-64'sd242468320), q28(64'sd965080986), q28(-64'sd246778261),
      q28(64'sd1944171785), q28(-64'sd238158379), q28(64'sd931381682)}};

  // Bandpass coefficients, b0..b4 then a1..a4, Q4.28; row 0 is the pass-through.
  localparam coef_t BandRom [5][9] = '{
    '{q28(64'sd1000000000), 32'sd0, 32'sd0, 32'sd0, 32'sd0,
      32'sd0, 32'sd0, 32'sd0, 32'sd0},
    '{q28(64'sd200138726), 32'sd0, q28(-64'sd400277451), 32'sd0,
      q28(64'sd200138726), q28(-64'sd2355934631), q28(64'sd1941257089),
      q28(-64'sd784706376), q28(64'sd199907605)},
    '{q28(64'sd5129268), 32'sd0, q28(-64'sd10258537), 32'sd0,
      q28(64'sd5129268), q28(-64'sd3678895470), q28(64'sd5179700414),
      q28(-64'sd3305801890), q28(64'sd807949591)},
    '{q28(64'sd117351037), 32'sd0, q28(-64'sd234702073), 32'sd0,
      q28(64'sd117351037), q28(-64'sd2137430180), q28(64'sd2038578008),
      q28(-64'sd1070144399), q28(64'sd294636528)},
    '{q28(64'sd175087644), 32'sd0, q28(-64'sd350175287), 32'sd0,
      q28(64'sd175087644), q28(-64'sd2299055356), q28(64'sd1967497760),
      q28(-64'sd874805556), q28(64'sd219653984)}};

  // Notch coefficient k of the selected mode; the unused code passes through.
  function automatic coef_t notch_coef(input logic [1:0] mode, input logic [3:0] k);
    coef_t c;
    logic [1:0] m;
    c = '0;
    m = (mode <= 2'd2) ? mode : 2'd0;
    if (k <= 4'd8) c = NotchRom[m][k];
    return c;
  endfunction

  // Bandpass coefficient k of the selected mode; unused codes pass through.
  function automatic coef_t band_coef(input logic [2:0] mode, input logic [3:0] k);
    coef_t c;
    logic [2:0] m;
    c = '0;
    m = (mode <= 3'd4) ? mode : 3'd0;
    if (k <= 4'd8) c = BandRom[m][k];
    return c;
  endfunction

endpackage
`default_nettype wire

[src/mnbi_if.sv]
// Valid/ready channel interfaces for the filter's input and result streams.
// Depends on mnbi_pkg.
`default_nettype none
interface mnbi_in_if import mnbi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic [ChanW-1:0]          chan;
  modport source (output valid, output sample, output chan, input ready);
  modport sink (input valid, input sample, input chan, output ready);
endinterface

interface mnbi_out_if import mnbi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] filtered;
  logic [ChanW-1:0]          out_chan;
  modport source (output valid, output filtered, output out_chan, input ready);
  modport sink (input valid, input filtered, input out_chan, output ready);
endinterface
`default_nettype wire

[src/mnbi_mac.sv]
// Shared multiply-accumulate unit: one Q4.28 by Q32.8 product a cycle, floored to Q32.8.
// Depends on mnbi_pkg.
`default_nettype none
module mnbi_mac import mnbi_pkg::*; (
  input  logic  clk,
  input  logic  clear,
  input  logic  en,
  input  logic  neg,
  input  coef_t coef,
  input  val_t  val,
  output val_t  acc
);
  // Product of the previous cycle is registered, then floored and added.
  logic signed [CoefW+ValW-1:0] prod_r;
  logic                         add_r, neg_r;
  logic signed [ValW+4:0]       acc_r;
  logic signed [ValW+4:0]       term;
  logic signed [ValW+4:0]       sum;

  always_ff @(posedge clk) begin
    prod_r <= coef * val;
    add_r  <= en;
    neg_r  <= neg;
  end

  always_comb begin
    term = (ValW+5)'(prod_r >>> 28);
    sum  = neg_r ? acc_r - term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (clear) acc_r <= '0;
    else if (add_r) acc_r <= sum;
  end

  // Saturate to 40 bits.
  always_comb begin
    if (acc_r > (ValW+5)'(signed'({1'b0, {(ValW-1){1'b1}}})))
      acc = {1'b0, {(ValW-1){1'b1}}};
    else if (acc_r < -(ValW+5)'(signed'({1'b0, 1'b1, {(ValW-1){1'b0}}}) >>> 1) * 2)
      acc = {1'b1, {(ValW-1){1'b0}}};
    else acc = acc_r[ValW-1:0];
  end
endmodule
`default_nettype wire

[src/mnbi_hist.sv]
// History memory: one store of tap values, four per word, one row per channel and delay.
// Depends on mnbi_pkg.
`default_nettype none
module mnbi_hist import mnbi_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [HistAw-1:0] waddr,
  input  logic [4*ValW-1:0] wdata,
  input  logic [HistAw-1:0] raddr,
  output logic [4*ValW-1:0] rdata
);
  // Each word holds notch in, notch out, band in, band out for one delay.
  logic [4*ValW-1:0] mem [HistDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/multichannel_notch_bandpass_iir.sv]
// Top level of the multichannel notch-then-bandpass IIR filter.
// Depends on mnbi_pkg, mnbi_if, mnbi_hist and mnbi_mac.
//
// Each transfer on the input carries one 24-bit sample and a channel number;
// one result transfer follows with the sample after a fourth-order notch and a
// fourth-order bandpass, both direct form I with fixed Q4.28 coefficients.
// Histories for every channel live in one memory of 4 words per channel, each
// word holding all four stage values for one delay. After reset a clearing
// pass writes zero to all 64 words, during which no input transfer is
// accepted. Each item then goes through these steps, with all products
// formed by the single shared multiplier: the idle state takes the
// transfer, the history is read, each stage forms nine products and then
// drains, four write-backs shift the history and the result is loaded. One
// item is handled at a time; the result waits in the output register while
// the next input is taken and worked on, and that item holds before loading
// its own result until the waiting one has been transferred.
// An out-of-range channel gives zero and leaves the histories alone.
`default_nettype none
module multichannel_notch_bandpass_iir import mnbi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mnbi_in_if.sink     in_ch,
  mnbi_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  localparam logic [2:0] S_CLR = 3'd0, S_IDLE = 3'd1, S_RD = 3'd2, S_NT = 3'd3,
                         S_BD = 3'd4, S_WB = 3'd5, S_FIN = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [HistAw:0] cnt_r, cnt_nxt;
  logic [1:0] notch_mode_r;
  logic [2:0] band_mode_r;
  logic signed [SampleW-1:0] smp_r;
  logic [ChanW-1:0] chan_r;
  logic [4*ValW-1:0] h_r [Dly];
  val_t nout_r;
  logic ov_r;
  logic signed [SampleW-1:0] res_r;
  logic [ChanW-1:0] rch_r;

  logic we;
  logic [HistAw-1:0] waddr, raddr;
  logic [4*ValW-1:0] wdata, rdata;
  logic mclr, men, mneg;
  coef_t mcoef;
  val_t mval, macc;
  logic [3:0] k;
  logic [1:0] d;
  logic fin_go;

  mnbi_hist u_hist (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  mnbi_mac u_mac (.clk, .clear(mclr), .en(men), .neg(mneg), .coef(mcoef), .val(mval),
                  .acc(macc));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notch_mode_r <= '0;
      band_mode_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CfgNotch) notch_mode_r <= cfg_data[1:0];
      else band_mode_r <= cfg_data;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  // The result register is loaded once it is empty or being emptied.
  assign fin_go = (state_r == S_FIN) && (!ov_r || out_ch.ready);
  // The read address is issued ahead of the capture so the memory latency stays hidden.
  assign raddr = {chan_r, 2'b00} + HistAw'(cnt_r[1:0]);
  assign k = cnt_r[3:0];
  assign d = (k == 4'd0) ? 2'd0 : (k <= 4'd4 ? 2'(k - 4'd1) : 2'(k - 4'd5));

  // History slice selection: word = {nin, nout, bin, bout}.
  function automatic val_t fld(input logic [4*ValW-1:0] w, input logic [1:0] f);
    return val_t'(w[(3-f)*ValW +: ValW]);
  endfunction

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    mclr = 1'b0;
    men = 1'b0;
    mneg = 1'b0;
    mcoef = '0;
    mval = '0;
    we = 1'b0;
    waddr = HistAw'(cnt_r);
    wdata = '0;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (HistAw+1)'(HistDepth - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cnt_nxt = '0;
        mclr = 1'b1;
        if (in_ch.valid && in_ch.ready)
          state_nxt = (32'(in_ch.chan) < NumChannels) ? S_RD : S_FIN;
      end
      S_RD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (HistAw+1)'(4)) begin
          cnt_nxt = '0;
          state_nxt = S_NT;
        end
      end
      S_NT, S_BD: begin
        cnt_nxt = cnt_r + 1'b1;
        if (k <= 4'd8) begin
          men = 1'b1;
          mneg = (k >= 4'd5);
          if (state_r == S_NT) begin
            mcoef = notch_coef(notch_mode_r, k);
            if (k == 4'd0) mval = val_t'(smp_r) <<< 8;
            else if (k <= 4'd4) mval = fld(h_r[d], 2'd0) <<< 8;
            else mval = fld(h_r[d], 2'd1);
          end else begin
            mcoef = band_coef(band_mode_r, k);
            if (k == 4'd0) mval = nout_r;
            else if (k <= 4'd4) mval = fld(h_r[d], 2'd2);
            else mval = fld(h_r[d], 2'd3);
          end
        end
        if (k == 4'd10) begin
          cnt_nxt = '0;
          mclr = (state_r == S_NT);
          state_nxt = (state_r == S_NT) ? S_BD : S_WB;
        end
      end
      S_WB: begin
        we = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        waddr = {chan_r, cnt_r[1:0]};
        if (cnt_r[1:0] == 2'd0)
          wdata = {val_t'(smp_r), nout_r, nout_r, macc};
        else
          wdata = h_r[2'(cnt_r[1:0] - 2'd1)];
        if (cnt_r == (HistAw+1)'(3)) state_nxt = S_FIN;
      end
      S_FIN: if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Truncation toward zero: a negative value is biased up before the shift.
  val_t bq;
  always_comb bq = (macc < 0) ? ((macc + 40'sd255) >>> 8) : (macc >>> 8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (out_ch.valid && out_ch.ready) ov_r <= 1'b0;
      if (fin_go) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      smp_r <= in_ch.sample;
      chan_r <= in_ch.chan;
    end
    if (state_r == S_RD && cnt_r != '0) h_r[2'(cnt_r - 1'b1)] <= rdata;
    if (state_r == S_NT && k == 4'd10) nout_r <= macc;
    if (fin_go) begin
      rch_r <= chan_r;
      if (32'(chan_r) >= NumChannels) res_r <= '0;
      else if (bq > 40'sd8388607) res_r <= 24'sh7FFFFF;
      else if (bq < -40'sd8388608) res_r <= 24'sh800000;
      else res_r <= bq[SampleW-1:0];
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.filtered = res_r;
  assign out_ch.out_chan = rch_r;

`ifndef ASSERT_OFF
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_wb_only: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_CLR || state_r == S_WB)) else $error("stray history write");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> out_ch.valid) else $error("result not presented");
`endif
endmodule
`default_nettype wire
